// ===== rtl/core/tqpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tqpm_pkg
// Shared types and constants of the two-queue pair matcher.
// ----------------------------------------------------------------------------
package tqpm_pkg;

  localparam int OP_W    = 2;
  localparam int ID_IO_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_REQ = 2'd0,
    OP_ADD_SRV = 2'd1,
    OP_MATCH   = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic enq;
    logic match;
    logic walk_init;
    logic walk_step;
    logic walk_fin;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic walk_done;
  } sts_t;

endpackage

// ===== rtl/core/tqpm_ram.sv =====
// ----------------------------------------------------------------------------
// tqpm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tqpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tqpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tqpm_ctrl
// Sequencer: accepts a request, dispatches it and steps the cancel walk.
// ----------------------------------------------------------------------------
module tqpm_ctrl
  import tqpm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_ADD_REQ, OP_ADD_SRV: begin
            cmd.enq   = 1'b1;
            state_nxt = ST_IDLE;
          end
          OP_MATCH: begin
            cmd.match = 1'b1;
            state_nxt = ST_IDLE;
          end
          OP_CANCEL: begin
            cmd.walk_init = 1'b1;
            state_nxt     = ST_WALK;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          cmd.walk_fin = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_DECODE))
    else $error("accepted request not decoded");

  a_walk_only_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE && sts.op != OP_CANCEL) |=> (state_r == ST_IDLE))
    else $error("walk entered for non-cancel request");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command issued");

endmodule

// ===== rtl/core/tqpm_dp.sv =====
// ----------------------------------------------------------------------------
// tqpm_dp
// Datapath: requester and server ring buffers, cancel compaction, result regs.
// ----------------------------------------------------------------------------
module tqpm_dp
  import tqpm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ID_IO_W-1:0] in_id,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_strobe,
  output logic               out_pair_valid,
  output logic [ID_IO_W-1:0] out_server_id,
  output logic [ID_IO_W-1:0] out_requester_id,
  output logic               out_overflow
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (ID_WIDTH < ID_IO_W) ? ID_WIDTH : ID_IO_W;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(QUEUE_DEPTH - 1)) r = '0;
    else                           r = p + AW'(1);
    return r;
  endfunction

  op_t               op_r, op_nxt;
  logic [SW-1:0]     id_r, id_nxt;
  logic [AW-1:0]     req_head_r, req_head_nxt, req_tail_r, req_tail_nxt;
  logic [CW-1:0]     req_cnt_r, req_cnt_nxt;
  logic [AW-1:0]     srv_head_r, srv_head_nxt, srv_tail_r, srv_tail_nxt;
  logic [CW-1:0]     srv_cnt_r, srv_cnt_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]     left_r, left_nxt, kept_r, kept_nxt;
  logic              pend_r, pend_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic              out_pair_r, out_pair_nxt;
  logic [ID_IO_W-1:0] out_srv_r, out_srv_nxt, out_req_r, out_req_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              req_we, srv_we;
  logic [AW-1:0]     req_waddr, req_raddr;
  logic [SW-1:0]     req_rdata, srv_rdata;

  tqpm_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (cmd.walk_step ? req_rdata : id_r),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  tqpm_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_srv_ram (
    .clk   (clk),
    .we    (srv_we),
    .waddr (srv_tail_r),
    .wdata (id_r),
    .raddr (srv_head_r),
    .rdata (srv_rdata)
  );

  assign req_raddr = cmd.walk_step ? rd_ptr_r : req_head_r;

  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    req_head_nxt   = req_head_r;
    req_tail_nxt   = req_tail_r;
    req_cnt_nxt    = req_cnt_r;
    srv_head_nxt   = srv_head_r;
    srv_tail_nxt   = srv_tail_r;
    srv_cnt_nxt    = srv_cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    left_nxt       = left_r;
    kept_nxt       = kept_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    out_pair_nxt   = 1'b0;
    out_srv_nxt    = '0;
    out_req_nxt    = '0;
    out_ovf_nxt    = 1'b0;
    req_we         = 1'b0;
    srv_we         = 1'b0;
    req_waddr      = req_tail_r;

    if (cmd.load) begin
      op_nxt = op_t'(in_operation);
      id_nxt = in_id[SW-1:0];
    end

    if (cmd.enq) begin
      out_strobe_nxt = 1'b1;
      if (op_r == OP_ADD_REQ) begin
        if (req_cnt_r == FULL) begin
          out_ovf_nxt = 1'b1;
        end else begin
          req_we       = 1'b1;
          req_tail_nxt = ptr_inc(req_tail_r);
          req_cnt_nxt  = req_cnt_r + CW'(1);
        end
      end else begin
        if (srv_cnt_r == FULL) begin
          out_ovf_nxt = 1'b1;
        end else begin
          srv_we       = 1'b1;
          srv_tail_nxt = ptr_inc(srv_tail_r);
          srv_cnt_nxt  = srv_cnt_r + CW'(1);
        end
      end
    end

    // head data was read while the request was being accepted
    if (cmd.match) begin
      out_strobe_nxt = 1'b1;
      if (req_cnt_r != '0 && srv_cnt_r != '0) begin
        out_pair_nxt           = 1'b1;
        out_srv_nxt[SW-1:0]    = srv_rdata;
        out_req_nxt[SW-1:0]    = req_rdata;
        req_head_nxt           = ptr_inc(req_head_r);
        req_cnt_nxt            = req_cnt_r - CW'(1);
        srv_head_nxt           = ptr_inc(srv_head_r);
        srv_cnt_nxt            = srv_cnt_r - CW'(1);
      end
    end

    if (cmd.walk_init) begin
      rd_ptr_nxt = req_head_r;
      wr_ptr_nxt = req_head_r;
      left_nxt   = req_cnt_r;
      kept_nxt   = '0;
      pend_nxt   = 1'b0;
    end

    // read ahead one entry, compact behind it
    if (cmd.walk_step) begin
      pend_nxt = 1'b0;
      if (left_r != '0) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        left_nxt   = left_r - CW'(1);
        pend_nxt   = 1'b1;
      end
      if (pend_r && req_rdata != id_r) begin
        req_we     = 1'b1;
        req_waddr  = wr_ptr_r;
        wr_ptr_nxt = ptr_inc(wr_ptr_r);
        kept_nxt   = kept_r + CW'(1);
      end
    end

    if (cmd.walk_fin) begin
      out_strobe_nxt = 1'b1;
      req_cnt_nxt    = kept_r;
      req_tail_nxt   = wr_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_head_r   <= '0;
      req_tail_r   <= '0;
      req_cnt_r    <= '0;
      srv_head_r   <= '0;
      srv_tail_r   <= '0;
      srv_cnt_r    <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      left_r       <= '0;
      kept_r       <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      req_head_r   <= req_head_nxt;
      req_tail_r   <= req_tail_nxt;
      req_cnt_r    <= req_cnt_nxt;
      srv_head_r   <= srv_head_nxt;
      srv_tail_r   <= srv_tail_nxt;
      srv_cnt_r    <= srv_cnt_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      left_r       <= left_nxt;
      kept_r       <= kept_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    out_pair_r <= out_pair_nxt;
    out_srv_r  <= out_srv_nxt;
    out_req_r  <= out_req_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign sts.op        = op_r;
  assign sts.walk_done = (left_r == '0) && !pend_r;

  assign out_strobe       = out_strobe_r;
  assign out_pair_valid   = out_pair_r;
  assign out_server_id    = out_srv_r;
  assign out_requester_id = out_req_r;
  assign out_overflow     = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (req_cnt_r <= FULL) && (srv_cnt_r <= FULL))
    else $error("queue count beyond depth");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (kept_r + left_r <= req_cnt_r))
    else $error("cancel walk keeps more than it read");

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !(out_pair_r && out_ovf_r))
    else $error("pair and overflow flagged together");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/core/two_queue_pair_matcher_core.sv =====
// ----------------------------------------------------------------------------
// two_queue_pair_matcher_core
// Requester and server FIFOs with head matching and requester cancel.
//
//   channel  ports                                   handshake
//   request  in_operation, in_id                     start & !busy
//   result   out_pair_valid, out_server_id,          out_strobe, one cycle
//            out_requester_id, out_overflow
//
// Enqueue and match: dispatched in DECODE, result strobed in the next cycle.
// Cancel: duration set by the walk through the requester RAM (one entry read
// and one compacted per cycle on its single ports).
// busy stays high until the request is finished; one request at a time.
// Synchronous active-low reset empties both queues; RAM contents are kept.
// Results cannot be stalled: out_strobe is high for exactly one cycle.
// ----------------------------------------------------------------------------
module two_queue_pair_matcher_core
  import tqpm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ID_IO_W-1:0] in_id,
  output logic               out_strobe,
  output logic               out_pair_valid,
  output logic [ID_IO_W-1:0] out_server_id,
  output logic [ID_IO_W-1:0] out_requester_id,
  output logic               out_overflow
);

  cmd_t cmd;
  sts_t sts;

  tqpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tqpm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_id            (in_id),
    .cmd              (cmd),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_pair_valid   (out_pair_valid),
    .out_server_id    (out_server_id),
    .out_requester_id (out_requester_id),
    .out_overflow     (out_overflow)
  );

endmodule
